FILE: sv/pid_map_allocator_defines.svh
// Assertion macros for the guest id allocator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PID_MAP_ALLOCATOR_DEFINES_SVH
`define PID_MAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define PMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PMA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PMA_ASSERT(lbl, prop, msg)
`define PMA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: sv/pma_pkg.sv
// Shared constants, codes and controller/datapath interface types of the allocator.
// No dependencies.
`default_nettype none
package pma_pkg;

  localparam int PID_SPACE = 32768;
  localparam int PID_W     = $clog2(PID_SPACE);
  localparam int HOST_W    = 23;
  localparam int KIND_W    = 3;
  localparam int STS_W     = 3;
  localparam int REV_DEPTH = 256;
  localparam int REV_AW    = $clog2(REV_DEPTH);
  localparam int RANGE_W   = PID_W + 1;
  localparam int DIV_W     = 32;
  localparam int DIV_CW    = $clog2(DIV_W);

  localparam logic [11:0]      HASH_MUL    = 12'd3779;
  localparam logic [PID_W-1:0] START_RESET = PID_W'(10);
  localparam logic [PID_W-1:0] LAST_RESET  = PID_W'(32767);

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_LAST  = 1'b1;

  typedef enum logic [2:0] {
    CMD_PERM        = 3'd0,
    CMD_RELATED     = 3'd1,
    CMD_CHILD       = 3'd2,
    CMD_LOOKUP      = 3'd3,
    CMD_LOOKUP_VH   = 3'd4,
    CMD_LOOKUP_HOST = 3'd5,
    CMD_FREE        = 3'd6
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_EMPTY   = 3'd0,
    KIND_PERM    = 3'd1,
    KIND_CHILD   = 3'd2,
    KIND_GROUP   = 3'd3,
    KIND_SESSION = 3'd4,
    KIND_SELF    = 3'd5,
    KIND_ROOT    = 3'd6
  } kind_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 3'd0,
    STS_NONE     = 3'd1,
    STS_FULL     = 3'd2,
    STS_USED     = 3'd3,
    STS_REV_FULL = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_G_RD, S_G_CHK, S_SCAN_GO, S_SCAN, S_SCAN_CHK,
    S_N_RD, S_N_CHK, S_PICK, S_DIV1, S_P0_RD, S_P0_CHK, S_HASH, S_DIV2_GO,
    S_DIV2, S_P_RD, S_P_CHK, S_COMMIT, S_FREE, S_EMIT
  } state_e;

  typedef enum logic [1:0] {RD_G, RD_NG, RD_P} rd_sel_e;

  typedef enum logic [1:0] {E_NONE, E_SLOT, E_NEW_G, E_NEW_P} eload_e;

  typedef struct packed {
    logic                  used;
    logic [KIND_W-1:0]     kind;
    logic [HOST_W-1:0]     host;
  } slot_t;

  typedef struct packed {
    logic [HOST_W-1:0] host;
    logic [PID_W-1:0]  guest;
  } rev_t;

  typedef struct packed {
    logic [PID_W-1:0]  guest;
    logic [HOST_W-1:0] host;
    logic [KIND_W-1:0] kind;
  } entry_t;

  typedef struct packed {
    logic    latch;
    logic    clr_step;
    rd_sel_e rd_sel;
    logic    scan_start;
    logic    scan_key_slot;
    logic    div_start;
    logic    div_hash;
    logic    p_mod;
    logic    hash_calc;
    logic    p_hash;
    logic    p_step;
    eload_e  e_load;
    logic    wr_alloc;
    logic    wr_free;
    logic    rev_add;
    logic    rev_drop;
    logic    emit;
    status_e emit_code;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic hneg;
    logic kind_ok;
    logic rd_used;
    logic rd_host_neg;
    logic clr_last;
    logic scan_done;
    logic rev_found;
    logic rev_free_ok;
    logic guest_eq;
    logic div_busy;
    logic win_empty;
    logic probe_end;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: sv/pma_div.sv
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
// Depends on pma_pkg.
`default_nettype none
module pma_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pma_pkg::DIV_W-1:0]    dividend_i,
  input  logic [pma_pkg::RANGE_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic [pma_pkg::RANGE_W-1:0]  rem_o
);
  import pma_pkg::*;

  logic                busy_q;
  logic [DIV_CW-1:0]   cnt_q;
  logic [RANGE_W-1:0]  rem_q, dvs_q;
  logic [DIV_W-1:0]    dvd_q;
  logic [RANGE_W:0]    trial;

  assign trial = {rem_q, dvd_q[DIV_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_q <= RANGE_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_q <= trial[RANGE_W-1:0];
      end
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

FILE: sv/pma_dpath.sv
// Datapath: slot and reverse memories, reverse scan, hashing, probing and result register.
// Depends on pma_pkg and pma_div.
`default_nettype none
module pma_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pma_pkg::ctrl_cmd_t           ctl_i,
  output pma_pkg::dp_stat_t            stat_o,
  input  logic [2:0]                   cmd_i,
  input  logic [pma_pkg::PID_W-1:0]    qnx_pid_i,
  input  logic [pma_pkg::HOST_W-1:0]   host_pid_i,
  input  logic [pma_pkg::KIND_W-1:0]   kind_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [pma_pkg::PID_W-1:0]    cfg_wdata_i,
  output logic                         out_valid_o,
  output logic [pma_pkg::STS_W-1:0]    status_o,
  output logic [pma_pkg::PID_W-1:0]    out_qnx_pid_o,
  output logic [pma_pkg::HOST_W-1:0]   out_host_pid_o,
  output logic [pma_pkg::KIND_W-1:0]   out_kind_o
);
  import pma_pkg::*;

  // Configuration window.
  logic [PID_W-1:0] start_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RESET;
      last_q  <= LAST_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_START) begin
        start_q <= cfg_wdata_i;
      end else begin
        last_q <= cfg_wdata_i;
      end
    end
  end

  // Latched item. Any negative host id is held as minus one.
  logic [2:0]        op_q;
  logic [PID_W-1:0]  g_q;
  logic [HOST_W-1:0] h_q;
  logic [KIND_W-1:0] kind_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      op_q   <= cmd_i;
      g_q    <= qnx_pid_i;
      h_q    <= host_pid_i[HOST_W-1] ? '1 : host_pid_i;
      kind_q <= kind_i;
    end
  end

  logic hneg, kind_ok;
  assign hneg    = h_q[HOST_W-1];
  assign kind_ok = kind_q inside {[KIND_GROUP:KIND_ROOT]};

  // Window arithmetic.
  logic [RANGE_W-1:0] range;
  logic               win_empty;
  logic [HOST_W:0]    diff;
  logic [HOST_W:0]    diff_abs;
  logic [DIV_W-1:0]   h_ext, hash_q;
  logic               div_busy;
  logic [RANGE_W-1:0] rem, rem_fix;

  assign win_empty = start_q > last_q;
  assign range     = {1'b0, last_q} - {1'b0, start_q} + RANGE_W'(1);
  assign diff      = {h_q[HOST_W-1], h_q} - (HOST_W+1)'(start_q);
  assign diff_abs  = diff[HOST_W] ? (HOST_W+1)'(-diff) : diff;
  assign h_ext     = {{(DIV_W-HOST_W){h_q[HOST_W-1]}}, h_q};
  // A negative difference with a nonzero remainder wraps to the positive residue.
  assign rem_fix   = (diff[HOST_W] && rem != '0) ? RANGE_W'(range - rem) : rem;

  always_ff @(posedge clk_i) begin
    if (ctl_i.hash_calc) begin
      hash_q <= DIV_W'(h_ext * DIV_W'(HASH_MUL)) + DIV_W'(start_q);
    end
  end

  pma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .dividend_i (ctl_i.div_hash ? hash_q : DIV_W'(diff_abs)),
    .divisor_i  (range),
    .busy_o     (div_busy),
    .rem_o      (rem)
  );

  // Probe pointer and count.
  logic [PID_W-1:0]   p_q;
  logic [RANGE_W-1:0] n_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.p_mod) begin
      p_q <= PID_W'(start_q + rem_fix);
    end else if (ctl_i.p_hash) begin
      p_q <= PID_W'(start_q + rem);
      n_q <= '0;
    end else if (ctl_i.p_step) begin
      p_q <= (p_q == last_q) ? start_q : PID_W'(p_q + 1'b1);
      n_q <= n_q + 1'b1;
    end
  end

  // Slot memory with the clearing pass counter.
  slot_t            slot_mem [PID_SPACE];
  slot_t            slot_rd_q, slot_wd;
  logic [PID_W-1:0] rd_addr, rd_addr_q, wr_addr, clr_q;
  logic             slot_we;
  entry_t           e_q;
  logic [PID_W-1:0] fguest_q;

  always_comb begin
    case (ctl_i.rd_sel)
      RD_NG:   rd_addr = fguest_q;
      RD_P:    rd_addr = p_q;
      default: rd_addr = g_q;
    endcase
  end

  always_comb begin
    slot_we = ctl_i.clr_step || ctl_i.wr_alloc || ctl_i.wr_free;
    wr_addr = g_q;
    slot_wd = '0;
    if (ctl_i.clr_step) begin
      wr_addr = clr_q;
    end else if (ctl_i.wr_alloc) begin
      wr_addr = e_q.guest;
      slot_wd = '{used: 1'b1, kind: e_q.kind, host: e_q.host};
    end
  end

  always_ff @(posedge clk_i) begin
    slot_rd_q <= slot_mem[rd_addr];
    rd_addr_q <= rd_addr;
    if (slot_we) begin
      slot_mem[wr_addr] <= slot_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Entry register: the entry that a successful result reports.
  logic [KIND_W-1:0] new_kind;

  always_comb begin
    case (op_q)
      CMD_PERM:    new_kind = KIND_PERM;
      CMD_RELATED: new_kind = kind_q;
      default:     new_kind = KIND_CHILD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.e_load)
      E_SLOT:  e_q <= '{guest: rd_addr_q, host: slot_rd_q.host, kind: slot_rd_q.kind};
      E_NEW_G: e_q <= '{guest: g_q, host: h_q, kind: new_kind};
      E_NEW_P: e_q <= '{guest: p_q, host: h_q, kind: new_kind};
      default: e_q <= e_q;
    endcase
  end

  // Reverse table: valid bits in flops, contents in memory, scanned one entry a cycle.
  logic [REV_DEPTH-1:0] valid_q;
  rev_t                 rev_mem [REV_DEPTH];
  rev_t                 rev_rd_q;
  logic [REV_AW-1:0]    scan_idx_q, rd_idx_q, fidx_q, free_idx_q;
  logic                 run_q, rd_v_q, found_q, free_ok_q, key_slot_q;
  logic [HOST_W-1:0]    key;
  logic                 hit, scan_done;

  assign key       = key_slot_q ? e_q.host : h_q;
  assign hit       = rd_v_q && valid_q[rd_idx_q] && (rev_rd_q.host == key);
  assign scan_done = rd_v_q && (rd_idx_q == REV_AW'(REV_DEPTH - 1));

  always_ff @(posedge clk_i) begin
    rev_rd_q <= rev_mem[scan_idx_q];
    rd_idx_q <= scan_idx_q;
    if (ctl_i.rev_add) begin
      rev_mem[free_idx_q] <= '{host: e_q.host, guest: e_q.guest};
    end
    if (hit && !found_q) begin
      fidx_q   <= rd_idx_q;
      fguest_q <= rev_rd_q.guest;
    end
    if (rd_v_q && !valid_q[rd_idx_q] && !free_ok_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (ctl_i.scan_start) begin
      key_slot_q <= ctl_i.scan_key_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      scan_idx_q <= '0;
      run_q      <= 1'b0;
      rd_v_q     <= 1'b0;
      found_q    <= 1'b0;
      free_ok_q  <= 1'b0;
    end else begin
      rd_v_q <= run_q;
      if (ctl_i.scan_start) begin
        scan_idx_q <= '0;
        run_q      <= 1'b1;
        found_q    <= 1'b0;
        free_ok_q  <= 1'b0;
      end else begin
        if (run_q) begin
          scan_idx_q <= scan_idx_q + 1'b1;
          if (scan_idx_q == REV_AW'(REV_DEPTH - 1)) begin
            run_q <= 1'b0;
          end
        end
        if (hit) begin
          found_q <= 1'b1;
        end
        if (rd_v_q && !valid_q[rd_idx_q]) begin
          free_ok_q <= 1'b1;
        end
      end
      if (ctl_i.rev_add) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (ctl_i.rev_drop) begin
        valid_q[fidx_q] <= 1'b0;
      end
    end
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      status_o <= ctl_i.emit_code;
      if (ctl_i.emit_code == STS_OK) begin
        out_qnx_pid_o  <= e_q.guest;
        out_host_pid_o <= e_q.host;
        out_kind_o     <= e_q.kind;
      end else begin
        out_qnx_pid_o  <= '0;
        out_host_pid_o <= '0;
        out_kind_o     <= KIND_EMPTY;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o.cmd         = cmd_e'(op_q);
    stat_o.hneg        = hneg;
    stat_o.kind_ok     = kind_ok;
    stat_o.rd_used     = slot_rd_q.used;
    stat_o.rd_host_neg = slot_rd_q.host[HOST_W-1];
    stat_o.clr_last    = (clr_q == PID_W'(PID_SPACE - 1));
    stat_o.scan_done   = scan_done;
    stat_o.rev_found   = found_q;
    stat_o.rev_free_ok = free_ok_q;
    stat_o.guest_eq    = (fguest_q == g_q);
    stat_o.div_busy    = div_busy;
    stat_o.win_empty   = win_empty;
    stat_o.probe_end   = (n_q == RANGE_W'(range - 1'b1));
  end

endmodule
`default_nettype wire

FILE: sv/pma_ctrl.sv
// Command sequencer of the allocator: decodes an item and steps the datapath.
// Depends on pma_pkg.
`default_nettype none
module pma_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  pma_pkg::dp_stat_t   stat_i,
  output pma_pkg::ctrl_cmd_t  ctl_o
);
  import pma_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (stat_i.clr_last) state_d = S_IDLE;
      S_IDLE:  if (start_i) state_d = S_DECODE;
      S_DECODE: begin
        case (stat_i.cmd)
          CMD_PERM, CMD_LOOKUP, CMD_LOOKUP_VH, CMD_FREE: state_d = S_G_RD;
          CMD_RELATED:
            state_d = (!stat_i.kind_ok || stat_i.hneg) ? S_IDLE : S_SCAN_GO;
          CMD_CHILD:       state_d = stat_i.hneg ? S_PICK : S_SCAN_GO;
          CMD_LOOKUP_HOST: state_d = stat_i.hneg ? S_IDLE : S_SCAN_GO;
          default:         state_d = S_IDLE;
        endcase
      end
      S_G_RD: state_d = S_G_CHK;
      S_G_CHK: begin
        case (stat_i.cmd)
          CMD_PERM: begin
            if (stat_i.rd_used) state_d = S_IDLE;
            else if (stat_i.hneg) state_d = S_COMMIT;
            else state_d = S_SCAN_GO;
          end
          CMD_LOOKUP, CMD_LOOKUP_VH: begin
            if (!stat_i.rd_used || (stat_i.cmd == CMD_LOOKUP_VH && stat_i.rd_host_neg)) begin
              state_d = S_IDLE;
            end else begin
              state_d = S_EMIT;
            end
          end
          CMD_FREE: begin
            if (!stat_i.rd_used) state_d = S_IDLE;
            else if (stat_i.rd_host_neg) state_d = S_FREE;
            else state_d = S_SCAN_GO;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN_GO: state_d = S_SCAN;
      S_SCAN:    if (stat_i.scan_done) state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        case (stat_i.cmd)
          CMD_PERM: begin
            if (stat_i.rev_found || !stat_i.rev_free_ok) state_d = S_IDLE;
            else state_d = S_COMMIT;
          end
          CMD_RELATED: begin
            if (stat_i.rev_found) state_d = S_N_RD;
            else if (!stat_i.rev_free_ok) state_d = S_IDLE;
            else state_d = S_PICK;
          end
          CMD_CHILD: begin
            if (stat_i.rev_found || !stat_i.rev_free_ok) state_d = S_IDLE;
            else state_d = S_PICK;
          end
          CMD_LOOKUP_HOST: state_d = stat_i.rev_found ? S_N_RD : S_IDLE;
          CMD_FREE:        state_d = S_FREE;
          default:         state_d = S_IDLE;
        endcase
      end
      S_N_RD:    state_d = S_N_CHK;
      S_N_CHK:   state_d = stat_i.rd_used ? S_EMIT : S_IDLE;
      S_PICK:    state_d = stat_i.win_empty ? S_IDLE : S_DIV1;
      S_DIV1:    if (!stat_i.div_busy) state_d = S_P0_RD;
      S_P0_RD:   state_d = S_P0_CHK;
      S_P0_CHK:  state_d = stat_i.rd_used ? S_HASH : S_COMMIT;
      S_HASH:    state_d = S_DIV2_GO;
      S_DIV2_GO: state_d = S_DIV2;
      S_DIV2:    if (!stat_i.div_busy) state_d = S_P_RD;
      S_P_RD:    state_d = S_P_CHK;
      S_P_CHK: begin
        if (!stat_i.rd_used) state_d = S_COMMIT;
        else if (stat_i.probe_end) state_d = S_IDLE;
        else state_d = S_P_RD;
      end
      S_COMMIT:  state_d = S_EMIT;
      S_FREE:    state_d = S_IDLE;
      S_EMIT:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath commands. Every exit to idle other than from clear carries a result.
  always_comb begin
    ctl_o = '0;
    ctl_o.rd_sel    = RD_G;
    ctl_o.e_load    = E_NONE;
    ctl_o.emit_code = STS_OK;
    case (state_q)
      S_CLEAR: ctl_o.clr_step = 1'b1;
      S_IDLE:  ctl_o.latch = start_i;
      S_DECODE: begin
        ctl_o.emit      = (state_d == S_IDLE);
        ctl_o.emit_code = STS_NONE;
      end
      S_G_RD: ctl_o.rd_sel = RD_G;
      S_G_CHK: begin
        ctl_o.emit = (state_d == S_IDLE);
        if (stat_i.cmd == CMD_PERM) begin
          ctl_o.emit_code = STS_USED;
          ctl_o.e_load    = E_NEW_G;
        end else begin
          ctl_o.emit_code = STS_NONE;
          ctl_o.e_load    = E_SLOT;
        end
      end
      S_SCAN_GO: begin
        ctl_o.scan_start    = 1'b1;
        ctl_o.scan_key_slot = (stat_i.cmd == CMD_FREE);
      end
      S_SCAN_CHK: begin
        ctl_o.emit = (state_d == S_IDLE);
        if (stat_i.rev_found) ctl_o.emit_code = STS_USED;
        else if (!stat_i.rev_free_ok) ctl_o.emit_code = STS_REV_FULL;
        if (stat_i.cmd == CMD_LOOKUP_HOST) ctl_o.emit_code = STS_NONE;
        ctl_o.e_load   = (stat_i.cmd == CMD_PERM) ? E_NEW_G : E_NONE;
        // The reverse entry goes only if it still points at the freed slot.
        ctl_o.rev_drop = (stat_i.cmd == CMD_FREE) && stat_i.rev_found && stat_i.guest_eq;
      end
      S_N_RD: ctl_o.rd_sel = RD_NG;
      S_N_CHK: begin
        ctl_o.e_load    = E_SLOT;
        ctl_o.emit      = !stat_i.rd_used;
        ctl_o.emit_code = STS_NONE;
      end
      S_PICK: begin
        ctl_o.div_start = !stat_i.win_empty;
        ctl_o.emit      = stat_i.win_empty;
        ctl_o.emit_code = STS_FULL;
      end
      S_DIV1:    ctl_o.p_mod = !stat_i.div_busy;
      S_P0_RD:   ctl_o.rd_sel = RD_P;
      S_P0_CHK:  ctl_o.e_load = E_NEW_P;
      S_HASH:    ctl_o.hash_calc = 1'b1;
      S_DIV2_GO: begin
        ctl_o.div_start = 1'b1;
        ctl_o.div_hash  = 1'b1;
      end
      S_DIV2:    ctl_o.p_hash = !stat_i.div_busy;
      S_P_RD:    ctl_o.rd_sel = RD_P;
      S_P_CHK: begin
        ctl_o.e_load    = E_NEW_P;
        ctl_o.p_step    = stat_i.rd_used && !stat_i.probe_end;
        ctl_o.emit      = stat_i.rd_used && stat_i.probe_end;
        ctl_o.emit_code = STS_FULL;
      end
      S_COMMIT: begin
        ctl_o.wr_alloc = 1'b1;
        ctl_o.rev_add  = !stat_i.hneg;
      end
      S_FREE: begin
        ctl_o.wr_free = 1'b1;
        ctl_o.emit    = 1'b1;
      end
      S_EMIT: ctl_o.emit = 1'b1;
      default: ctl_o.latch = 1'b0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

FILE: sv/pid_map_allocator.sv
// Top level of the host-to-guest process id allocator.
// Depends on pma_pkg, pma_ctrl, pma_dpath and pid_map_allocator_defines.svh.
//
//  Channel   Handshake                 Fields
//  item in   start_i, accepted !busy_o cmd_i, qnx_pid_i, host_pid_i, kind_i
//  result    out_valid_o, one cycle    status_o, out_qnx_pid_o, out_host_pid_o, out_kind_o
//  config    cfg_we_i, no wait         cfg_idx_i, cfg_wdata_i
//
// After reset the slot memory is cleared one entry a cycle: busy_o stays high until
// the last entry is cleared, configuration writes are taken meanwhile.
// Commands that search the reverse table scan it one entry a cycle. A hashed
// allocation adds a divider wait for the home slot and, if that slot is used, a second
// one for the hash, then probes slots one by one through the single slot memory port.
// The result is shown in the first cycle that busy_o is low; the receiver cannot stall it.
`default_nettype none
module pid_map_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [2:0]                          cmd_i,
  input  logic [pma_pkg::PID_W-1:0]           qnx_pid_i,
  input  logic signed [pma_pkg::HOST_W-1:0]   host_pid_i,
  input  logic [pma_pkg::KIND_W-1:0]          kind_i,
  output logic                                out_valid_o,
  output logic [pma_pkg::STS_W-1:0]           status_o,
  output logic [pma_pkg::PID_W-1:0]           out_qnx_pid_o,
  output logic signed [pma_pkg::HOST_W-1:0]   out_host_pid_o,
  output logic [pma_pkg::KIND_W-1:0]          out_kind_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [pma_pkg::PID_W-1:0]           cfg_wdata_i
);
  import pma_pkg::*;
  `include "pid_map_allocator_defines.svh"

  ctrl_cmd_t ctl;
  dp_stat_t  stat;
  logic      err_out;

  pma_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .ctl_o   (ctl)
  );

  pma_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .cmd_i          (cmd_i),
    .qnx_pid_i      (qnx_pid_i),
    .host_pid_i     (host_pid_i),
    .kind_i         (kind_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .out_qnx_pid_o  (out_qnx_pid_o),
    .out_host_pid_o (out_host_pid_o),
    .out_kind_o     (out_kind_o)
  );

  assign err_out = out_valid_o && (status_o != STS_OK);

  `PMA_ASSERT(a_result_when_idle, out_valid_o |-> !busy_o, "result while still busy")
  `PMA_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "item accepted without busy")
  `PMA_ASSERT(a_error_zero, err_out |-> (out_kind_o == KIND_EMPTY), "error result has entry")
  `PMA_ASSERT_RST(a_reset_quiet, !rst_ni |-> !out_valid_o, "result during reset")

endmodule
`default_nettype wire

FILE: verif/pid_map_allocator_checker.sv
// Watches the item, result and configuration channels of pid_map_allocator,
// predicts each result and compares it with what the block answers.
// Depends on pma_pkg.
module pid_map_allocator_checker
  import pma_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [2:0]                cmd_i,
  input  logic [PID_W-1:0]          qnx_pid_i,
  input  logic [HOST_W-1:0]         host_pid_i,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic                      out_valid_i,
  input  logic [STS_W-1:0]          status_i,
  input  logic [PID_W-1:0]          out_qnx_pid_i,
  input  logic [HOST_W-1:0]         out_host_pid_i,
  input  logic [KIND_W-1:0]         out_kind_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [PID_W-1:0]          cfg_wdata_i,
  output int                        errors_o,
  output int                        outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e           st;
    logic [PID_W-1:0]  guest;
    logic [HOST_W-1:0] host;
    logic [KIND_W-1:0] kind;
  } answer_t;

  int unsigned win_lo, win_hi;
  bit          slot_used [PID_SPACE];
  logic [2:0]  slot_kind [PID_SPACE];
  int          slot_host [PID_SPACE];
  bit          map_valid [REV_DEPTH];
  int          map_host  [REV_DEPTH];
  int          map_guest [REV_DEPTH];
  answer_t     answer_q[$];

  function automatic answer_t refuse(status_e st);
    return '{st: st, guest: '0, host: '0, kind: '0};
  endfunction

  function automatic answer_t slot_answer(int g);
    return '{st: STS_OK, guest: g[PID_W-1:0], host: slot_host[g][HOST_W-1:0],
             kind: slot_kind[g]};
  endfunction

  function automatic int map_lookup(int h);
    if (h < 0) return -1;
    for (int i = 0; i < REV_DEPTH; i++)
      if (map_valid[i] && map_host[i] == h) return i;
    return -1;
  endfunction

  function automatic int map_vacancy();
    for (int i = 0; i < REV_DEPTH; i++)
      if (!map_valid[i]) return i;
    return -1;
  endfunction

  // Home slot by reduction modulo the window size first; on a collision, linear probing from the hash.
  function automatic bit find_slot(int h, output int g);
    longint lo, hi, rng, r, p;
    bit [31:0] hs;
    lo = win_lo;
    hi = (win_hi > PID_SPACE - 1) ? PID_SPACE - 1 : win_hi;
    g = 0;
    if (lo > hi) return 0;
    rng = hi - lo + 1;
    r = (longint'(h) - lo) % rng;
    if (r < 0) r += rng;
    p = lo + r;
    if (!slot_used[p]) begin
      g = int'(p);
      return 1;
    end
    hs = 32'(h) * 32'd3779 + 32'(lo);
    p = lo + longint'({32'b0, hs}) % rng;
    for (longint n = 0; n < rng; n++) begin
      if (!slot_used[p]) begin
        g = int'(p);
        return 1;
      end
      p = (p == hi) ? lo : p + 1;
    end
    return 0;
  endfunction

  function automatic void claim(int g, logic [2:0] k, int h, int fi);
    slot_used[g] = 1;
    slot_kind[g] = k;
    slot_host[g] = h;
    if (fi >= 0) begin
      map_valid[fi] = 1;
      map_host[fi]  = h;
      map_guest[fi] = g;
    end
  endfunction

  function automatic answer_t predict_answer(logic [2:0] cmd, int g, logic [HOST_W-1:0] hraw,
                                             logic [2:0] k);
    int h, ri, fi, ng;
    answer_t a;
    h = hraw[HOST_W-1] ? -1 : int'(hraw);
    case (cmd)
      CMD_PERM: begin
        if (slot_used[g] || map_lookup(h) >= 0) return refuse(STS_USED);
        fi = -1;
        if (h >= 0) begin
          fi = map_vacancy();
          if (fi < 0) return refuse(STS_REV_FULL);
        end
        claim(g, KIND_PERM, h, fi);
        return slot_answer(g);
      end
      CMD_RELATED: begin
        if (k < KIND_GROUP || k > KIND_ROOT || h < 0) return refuse(STS_NONE);
        ri = map_lookup(h);
        if (ri >= 0) begin
          ng = map_guest[ri];
          return slot_used[ng] ? slot_answer(ng) : refuse(STS_NONE);
        end
        fi = map_vacancy();
        if (fi < 0) return refuse(STS_REV_FULL);
        if (!find_slot(h, ng)) return refuse(STS_FULL);
        claim(ng, k, h, fi);
        return slot_answer(ng);
      end
      CMD_CHILD: begin
        if (map_lookup(h) >= 0) return refuse(STS_USED);
        fi = -1;
        if (h >= 0) begin
          fi = map_vacancy();
          if (fi < 0) return refuse(STS_REV_FULL);
        end
        if (!find_slot(h, ng)) return refuse(STS_FULL);
        claim(ng, KIND_CHILD, h, fi);
        return slot_answer(ng);
      end
      CMD_LOOKUP, CMD_LOOKUP_VH: begin
        if (!slot_used[g]) return refuse(STS_NONE);
        if (cmd == CMD_LOOKUP_VH && slot_host[g] < 0) return refuse(STS_NONE);
        return slot_answer(g);
      end
      CMD_LOOKUP_HOST: begin
        ri = map_lookup(h);
        if (ri < 0) return refuse(STS_NONE);
        ng = map_guest[ri];
        return slot_used[ng] ? slot_answer(ng) : refuse(STS_NONE);
      end
      CMD_FREE: begin
        if (!slot_used[g]) return refuse(STS_NONE);
        a = slot_answer(g);
        ri = map_lookup(slot_host[g]);
        if (ri >= 0 && map_guest[ri] == g) map_valid[ri] = 0;
        slot_used[g] = 0;
        slot_kind[g] = KIND_EMPTY;
        slot_host[g] = 0;
        return a;
      end
      default: return refuse(STS_NONE);
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      win_lo = START_RESET;
      win_hi = LAST_RESET;
      for (int i = 0; i < PID_SPACE; i++) begin
        slot_used[i] = 0;
        slot_kind[i] = KIND_EMPTY;
        slot_host[i] = 0;
      end
      for (int i = 0; i < REV_DEPTH; i++) map_valid[i] = 0;
      answer_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_START) win_lo = cfg_wdata_i;
        else win_hi = cfg_wdata_i;
      end
      if (out_valid_i) begin
        if (answer_q.size() == 0) begin
          report("result with no item waiting", 32'd1, 32'd0);
        end else begin
          want = answer_q.pop_front();
          if (status_i != want.st) report("status", status_i, want.st);
          if (out_qnx_pid_i != want.guest) report("guest id", out_qnx_pid_i, want.guest);
          if (out_host_pid_i != want.host) report("host id", out_host_pid_i, want.host);
          if (out_kind_i != want.kind) report("kind", out_kind_i, want.kind);
        end
      end
      if (start_i && !busy_i)
        answer_q.push_back(predict_answer(cmd_i, int'(qnx_pid_i), host_pid_i, kind_i));
    end
    outstanding_o = answer_q.size();
  end
endmodule

FILE: verif/pid_map_allocator_tb.sv
// Testbench top for pid_map_allocator: clock, reset, item and configuration stimulus,
// and the verdict. Depends on pma_pkg, pid_map_allocator and pid_map_allocator_checker.
module pid_map_allocator_tb;
  import pma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b1;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         cmd_i = '0;
  logic [PID_W-1:0]   qnx_pid_i = '0;
  logic [HOST_W-1:0]  host_pid_i = '0;
  logic [KIND_W-1:0]  kind_i = '0;
  logic               out_valid_o;
  logic [STS_W-1:0]   status_o;
  logic [PID_W-1:0]   out_qnx_pid_o;
  logic [HOST_W-1:0]  out_host_pid_o;
  logic [KIND_W-1:0]  out_kind_o;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = CFG_START;
  logic [PID_W-1:0]   cfg_wdata_i = '0;
  int                 errors, outstanding, quiet_cycles;
  int unsigned        cur_lo, cur_hi;
  bit                 allow_gaps;

  always #5 clk_i = ~clk_i;

  pid_map_allocator uut (.*);

  pid_map_allocator_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .cmd_i, .qnx_pid_i, .host_pid_i, .kind_i,
    .out_valid_i(out_valid_o), .status_i(status_o), .out_qnx_pid_i(out_qnx_pid_o),
    .out_host_pid_i(out_host_pid_o), .out_kind_i(out_kind_o), .cfg_we_i, .cfg_idx_i,
    .cfg_wdata_i, .errors_o(errors), .outstanding_o(outstanding)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || out_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("pid_map_allocator_tb: errors");
      $finish;
    end
  end

  // Leaves start high so a following item can go out back to back.
  task automatic send(cmd_e c, int g, logic [HOST_W-1:0] h, logic [2:0] k);
    start_i <= 1'b1;
    cmd_i <= c;
    qnx_pid_i <= g[PID_W-1:0];
    host_pid_i <= h;
    kind_i <= k;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_window(int unsigned lo, int unsigned hi);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_START;
    cfg_wdata_i <= lo[PID_W-1:0];
    @(posedge clk_i);
    cfg_idx_i <= CFG_LAST;
    cfg_wdata_i <= hi[PID_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  task automatic random_item();
    int r, g, top;
    logic [HOST_W-1:0] h;
    logic [2:0] k;
    cmd_e c;
    r = $urandom_range(0, 99);
    c = r < 18 ? CMD_PERM : r < 36 ? CMD_RELATED : r < 56 ? CMD_CHILD :
        r < 64 ? CMD_LOOKUP : r < 70 ? CMD_LOOKUP_VH : r < 80 ? CMD_LOOKUP_HOST :
        r < 97 ? CMD_FREE : cmd_e'(3'd7);
    r = $urandom_range(0, 99);
    h = r < 70 ? HOST_W'($urandom_range(0, 300)) : r < 80 ? '1 :
        r < 90 ? HOST_W'($urandom) : HOST_W'($urandom_range(4194000, 4194303));
    r = $urandom_range(0, 99);
    top = (cur_lo + 63 > cur_hi) ? cur_hi : cur_lo + 63;
    if (r < 70 && cur_lo <= cur_hi) g = $urandom_range(cur_lo, top);
    else if (r < 85) g = $urandom_range(0, 300);
    else g = $urandom_range(0, PID_SPACE - 1);
    k = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(KIND_GROUP, KIND_ROOT))
                                     : 3'($urandom_range(0, 7));
    send(c, g, h, k);
    if (allow_gaps && $urandom_range(0, 99) < 30) pause($urandom_range(1, 13));
  endtask

  initial begin
    rst_ni <= 1'b0;
    allow_gaps = 1'b1;
    cur_lo = START_RESET;
    cur_hi = LAST_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The slot memory is cleared after reset; the first item waits on busy.
    @(posedge clk_i);

    send(CMD_PERM, 0, 23'd0, 3'd0);
    send(CMD_PERM, 0, 23'd77, 3'd0);
    send(CMD_PERM, 32767, 23'h3FFFFF, 3'd7);
    send(CMD_LOOKUP, 0, 23'd0, 3'd0);
    send(CMD_LOOKUP_VH, 32767, 23'd0, 3'd0);
    send(CMD_LOOKUP_HOST, 0, 23'h3FFFFF, 3'd0);
    send(CMD_RELATED, 0, 23'd5, KIND_GROUP);
    send(CMD_RELATED, 0, 23'd5, KIND_ROOT);
    send(CMD_RELATED, 0, 23'd6, 3'd7);
    send(CMD_RELATED, 0, 23'd6, KIND_EMPTY);
    send(CMD_RELATED, 0, '1, KIND_SELF);
    send(CMD_RELATED, 0, 23'd8, KIND_SESSION);
    send(CMD_CHILD, 0, '1, 3'd0);
    send(CMD_CHILD, 0, 23'd5, 3'd0);
    send(CMD_CHILD, 0, 23'h400005, 3'd0);
    send(CMD_PERM, 20, '1, 3'd0);
    send(CMD_LOOKUP_VH, 20, 23'd0, 3'd0);
    send(CMD_LOOKUP_HOST, 0, '1, 3'd0);
    send(CMD_FREE, 0, 23'd0, 3'd0);
    send(CMD_FREE, 0, 23'd0, 3'd0);
    send(CMD_LOOKUP_HOST, 0, 23'd0, 3'd0);
    send(cmd_e'(3'd7), 32767, '1, 3'd7);
    send(CMD_LOOKUP, 12345, 23'd0, 3'd0);

    // Tiny window: fills up and then reports full.
    set_window(20, 27);
    for (int i = 0; i < 10; i++) send(CMD_CHILD, 0, '1, 3'd0);
    send(CMD_RELATED, 0, 23'd900, KIND_SELF);
    for (int g = 20; g < 28; g += 2) send(CMD_FREE, g, 23'd0, 3'd0);

    // Empty window: every hashed allocation fails.
    set_window(50, 40);
    send(CMD_CHILD, 0, 23'd901, 3'd0);
    send(CMD_RELATED, 0, 23'd902, KIND_GROUP);
    send(CMD_PERM, 45, 23'd903, 3'd0);

    // Fill the host map until it overflows, then empty the window again.
    set_window(100, 499);
    for (int i = 0; i < 262; i++) send(CMD_CHILD, 0, HOST_W'(5000 + i), 3'd0);
    send(CMD_PERM, 600, 23'd9999, 3'd0);
    send(CMD_RELATED, 0, 23'd9998, KIND_SESSION);
    send(CMD_PERM, 601, '1, 3'd0);
    for (int g = 100; g < 500; g++) send(CMD_FREE, g, 23'd0, 3'd0);
    send(CMD_FREE, 600, 23'd0, 3'd0);
    send(CMD_FREE, 601, 23'd0, 3'd0);

    set_window(0, 32767);
    repeat (140) random_item();
    set_window(32767, 32767);
    repeat (100) random_item();
    set_window(200, 263);
    repeat (140) random_item();
    set_window(5, 1000);
    allow_gaps = 1'b0;
    repeat (120) random_item();

    settle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("pid_map_allocator_tb: clean");
    else $display("pid_map_allocator_tb: errors");
    $finish;
  end
endmodule
